// ----- design/assert_macros.svh -----
// Assertion macros shared by the quaternion accumulator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// Checked on every rising edge of clk_i, disabled while rst_ni is low.
`define QPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define QPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`else

`define QPA_ASSERT(lbl, prop, msg)
`define QPA_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

// ----- design/qpa_pkg.sv -----
// Types, constants and product term tables for the quaternion accumulator.
package qpa_pkg;

  localparam int FracBits = 14;
  localparam int CompWidth = 16;
  localparam int NumComp = 4;
  localparam int OpW = 2;

  localparam int QuatW = NumComp * CompWidth;
  localparam int TdataW = ((QuatW + 7) / 8) * 8;
  localparam int ProdW = 2 * CompWidth;
  localparam int SumW = (2 * CompWidth + 2 > FracBits + CompWidth + 1) ?
                        2 * CompWidth + 2 : FracBits + CompWidth + 1;
  localparam int ShW = SumW - FracBits;

  localparam logic [1:0] IdxX = 2'd0;
  localparam logic [1:0] IdxY = 2'd1;
  localparam logic [1:0] IdxZ = 2'd2;
  localparam logic [1:0] IdxW = 2'd3;

  typedef logic [CompWidth-1:0] comp_t;
  typedef logic [NumComp-1:0][CompWidth-1:0] quat_t;

  typedef enum logic [OpW-1:0] {
    OpLoad    = 2'd0,
    OpPremul  = 2'd1,
    OpPostmul = 2'd2,
    OpRead    = 2'd3
  } opcode_e;

  typedef struct packed {
    comp_t res;
    logic  sat;
  } lane_res_t;

  typedef struct packed {
    logic  sat;
    quat_t quat;
  } payload_t;

  localparam comp_t CompMax = {1'b0, {(CompWidth-1){1'b1}}};
  localparam comp_t IdentityW = (FracBits > CompWidth - 2) ? CompMax :
                                (comp_t'(1) << FracBits);
  localparam quat_t IdentityQuat = {IdentityW, comp_t'(0), comp_t'(0), comp_t'(0)};

  // Hamilton product a*b, lane = result component, term = one of four products
  localparam logic [1:0] TermA [NumComp][NumComp] = '{
    '{IdxW, IdxX, IdxY, IdxZ},
    '{IdxW, IdxX, IdxY, IdxZ},
    '{IdxW, IdxX, IdxY, IdxZ},
    '{IdxW, IdxX, IdxY, IdxZ}
  };
  localparam logic [1:0] TermB [NumComp][NumComp] = '{
    '{IdxX, IdxW, IdxZ, IdxY},
    '{IdxY, IdxZ, IdxW, IdxX},
    '{IdxZ, IdxY, IdxX, IdxW},
    '{IdxW, IdxX, IdxY, IdxZ}
  };
  localparam logic TermNeg [NumComp][NumComp] = '{
    '{1'b0, 1'b0, 1'b0, 1'b1},
    '{1'b0, 1'b1, 1'b0, 1'b0},
    '{1'b0, 1'b0, 1'b1, 1'b0},
    '{1'b0, 1'b1, 1'b1, 1'b1}
  };

endpackage

// ----- design/qpa_lane.sv -----
// One product lane: signed four-term dot product, round half up, saturate.
module qpa_lane (
  input  qpa_pkg::quat_t            lhs_i,
  input  qpa_pkg::quat_t            rhs_i,
  input  logic [qpa_pkg::NumComp-1:0] neg_i,
  output qpa_pkg::lane_res_t        res_o
);
  import qpa_pkg::*;

  localparam logic signed [SumW-1:0] RoundConst = SumW'(1) <<< (FracBits - 1);

  logic signed [ProdW-1:0] prod [NumComp];
  logic signed [SumW-1:0]  term [NumComp];
  logic signed [SumW-1:0]  sum;
  logic signed [SumW-1:0]  shifted;
  logic [ShW-1:0]          trunc;
  logic                    fits;

  for (genvar t = 0; t < NumComp; t++) begin : g_term
    assign prod[t] = $signed(lhs_i[t]) * $signed(rhs_i[t]);
    assign term[t] = neg_i[t] ? -SumW'(prod[t]) : SumW'(prod[t]);
  end

  always_comb begin
    sum = RoundConst;
    for (int t = 0; t < NumComp; t++) begin
      sum = sum + term[t];
    end
  end

  assign shifted = sum >>> FracBits;
  assign trunc = shifted[ShW-1:0];
  assign fits = (&trunc[ShW-1:CompWidth-1]) || !(|trunc[ShW-1:CompWidth-1]);

  always_comb begin
    if (fits) begin
      res_o.res = trunc[CompWidth-1:0];
      res_o.sat = 1'b0;
    end else begin
      res_o.res = trunc[ShW-1] ? ~CompMax : CompMax;
      res_o.sat = 1'b1;
    end
  end

endmodule

// ----- design/qpa_skid.sv -----
// Output register with one skid entry between the accumulator and the result stream.
module qpa_skid (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  qpa_pkg::payload_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output qpa_pkg::payload_t out_data_o
);
  import qpa_pkg::*;

  `include "assert_macros.svh"

  logic     out_valid_q, out_valid_d;
  logic     skid_valid_q, skid_valid_d;
  payload_t out_data_q, out_data_d;
  payload_t skid_data_q, skid_data_d;
  logic     push;
  logic     drain;

  assign in_ready_o = !skid_valid_q;
  assign push = in_valid_i && in_ready_o;
  assign drain = out_valid_q && out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_data_d = out_data_q;
    skid_data_d = skid_data_q;
    priority if (skid_valid_q) begin
      if (drain) begin
        out_data_d = skid_data_q;
        skid_valid_d = 1'b0;
      end
    end else if (push) begin
      if (!out_valid_q || drain) begin
        out_data_d = in_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_data_d = in_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (drain) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o = out_data_q;

  `QPA_ASSERT(a_skid_needs_out, skid_valid_q |-> out_valid_q, "skid full with output empty")
  `QPA_ASSERT(a_skid_holds, skid_valid_q && !out_ready_i |=> skid_valid_q && $stable(skid_data_q), "skid entry lost")
  `QPA_ASSERT(a_out_holds, out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_data_q), "stalled result changed")
  `QPA_ASSERT_ALWAYS(a_reset_empty, !rst_ni |=> !out_valid_o && in_ready_o, "buffer not empty in reset")

endmodule

// ----- design/quaternion_product_accumulator_top.sv -----
// Quaternion product accumulator: four product lanes, merge and state register, output buffer.
// Throughput: one transaction per clock while s_axis_tready is high; the four lanes and
// merge settle combinationally against the stored quaternion, written back at the accept edge.
// Output: each accepted result is registered in the output buffer and held on m_axis until taken.
// A two-entry output buffer keeps s_axis_tready high while one result is stalled.
// Reset (rst_ni low, async): stored quaternion set to identity, output buffer emptied.
module quaternion_product_accumulator_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [qpa_pkg::TdataW-1:0]  s_axis_tdata,  // op_x, op_y, op_z, op_w
  input  logic [qpa_pkg::OpW-1:0]     s_axis_tuser,  // opcode
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [qpa_pkg::TdataW-1:0]  m_axis_tdata,  // res_x, res_y, res_z, res_w
  output logic                        m_axis_tuser   // saturated
);
  import qpa_pkg::*;

  `include "assert_macros.svh"

  quat_t     state_q, state_d;
  quat_t     operand;
  quat_t     lhs_src;
  quat_t     rhs_src;
  quat_t     prod_quat;
  quat_t     next_quat;
  opcode_e   opcode;
  logic      next_sat;
  logic      prod_sat;
  logic      fire;
  lane_res_t lane_res [NumComp];
  logic [NumComp-1:0] lane_sat;
  payload_t  buf_in;
  payload_t  buf_out;

  assign opcode = opcode_e'(s_axis_tuser);
  assign operand = quat_t'(s_axis_tdata[QuatW-1:0]);
  assign lhs_src = (opcode == OpPremul) ? operand : state_q;
  assign rhs_src = (opcode == OpPremul) ? state_q : operand;

  for (genvar l = 0; l < NumComp; l++) begin : g_lane
    quat_t              lhs;
    quat_t              rhs;
    logic [NumComp-1:0] neg;

    for (genvar t = 0; t < NumComp; t++) begin : g_sel
      assign lhs[t] = lhs_src[TermA[l][t]];
      assign rhs[t] = rhs_src[TermB[l][t]];
      assign neg[t] = TermNeg[l][t];
    end

    qpa_lane u_lane (
      .lhs_i (lhs),
      .rhs_i (rhs),
      .neg_i (neg),
      .res_o (lane_res[l])
    );

    assign prod_quat[l] = lane_res[l].res;
    assign lane_sat[l] = lane_res[l].sat;
  end

  assign prod_sat = |lane_sat;

  always_comb begin
    unique case (opcode)
      OpLoad: begin
        next_quat = operand;
        next_sat = 1'b0;
      end
      OpPremul, OpPostmul: begin
        next_quat = prod_quat;
        next_sat = prod_sat;
      end
      OpRead: begin
        next_quat = state_q;
        next_sat = 1'b0;
      end
      default: begin
        next_quat = state_q;
        next_sat = 1'b0;
      end
    endcase
  end

  assign fire = s_axis_tvalid && s_axis_tready;
  assign state_d = fire ? next_quat : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IdentityQuat;
    end else begin
      state_q <= state_d;
    end
  end

  assign buf_in.quat = next_quat;
  assign buf_in.sat = next_sat;

  qpa_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (buf_in),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (buf_out)
  );

  assign m_axis_tdata = TdataW'(buf_out.quat);
  assign m_axis_tuser = buf_out.sat;

  `QPA_ASSERT(a_load_state, fire && opcode == OpLoad |=> state_q == $past(operand), "load not stored")
  `QPA_ASSERT(a_read_keeps, fire && opcode == OpRead |=> $stable(state_q), "read changed state")
  `QPA_ASSERT(a_idle_keeps, !fire |=> $stable(state_q), "state changed without transaction")
  `QPA_ASSERT(a_sat_only_mul, fire && (opcode == OpLoad || opcode == OpRead) |-> !buf_in.sat, "saturation flagged without product")

endmodule

// ----- test/quaternion_product_accumulator_top_tb.sv -----
// Self-checking testbench for the quaternion product accumulator: stream stimulus and scoreboard.
`timescale 1ns / 1ps

module quaternion_product_accumulator_top_tb;
  import qpa_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int HoldCycles    = 300;
  localparam int RandItems     = 630;
  localparam int ReportMax     = 10;

  // Orientation predictor and queue of expected stream results
  class orientation_scoreboard;
    longint   orient [NumComp];
    payload_t expected_q [$];
    int       mismatches;
    int       n_ops [NumComp];
    int       n_sat;

    function new();
      orient[IdxX] = 0;
      orient[IdxY] = 0;
      orient[IdxZ] = 0;
      orient[IdxW] = (FracBits > CompWidth - 2) ? (longint'(1) <<< (CompWidth - 1)) - 1 :
                                                  longint'(1) <<< FracBits;
      mismatches = 0;
      n_sat = 0;
      foreach (n_ops[i]) n_ops[i] = 0;
    endfunction

    function longint round_sat(longint s, inout bit sat);
      longint hi;
      longint lo;
      longint v;
      hi = (longint'(1) <<< (CompWidth - 1)) - 1;
      lo = -hi - 1;
      v = (s + (longint'(1) <<< (FracBits - 1))) >>> FracBits;
      if (v > hi) begin
        sat = 1'b1;
        v = hi;
      end else if (v < lo) begin
        sat = 1'b1;
        v = lo;
      end
      return v;
    endfunction

    // r = a*b
    function void hamilton(input longint a [NumComp], input longint b [NumComp],
                           output longint r [NumComp], output bit sat);
      longint ax, ay, az, aw, bx, by, bz, bw;
      ax = a[IdxX]; ay = a[IdxY]; az = a[IdxZ]; aw = a[IdxW];
      bx = b[IdxX]; by = b[IdxY]; bz = b[IdxZ]; bw = b[IdxW];
      sat = 1'b0;
      r[IdxX] = round_sat(aw * bx + ax * bw + ay * bz - az * by, sat);
      r[IdxY] = round_sat(aw * by - ax * bz + ay * bw + az * bx, sat);
      r[IdxZ] = round_sat(aw * bz + ax * by - ay * bx + az * bw, sat);
      r[IdxW] = round_sat(aw * bw - ax * bx - ay * by - az * bz, sat);
    endfunction

    function void note_item(opcode_e op, logic [TdataW-1:0] data);
      longint   opnd [NumComp];
      longint   prod [NumComp];
      bit       sat;
      payload_t e;
      sat = 1'b0;
      for (int i = 0; i < NumComp; i++)
        opnd[i] = longint'(signed'(data[i*CompWidth +: CompWidth]));
      case (op)
        OpLoad: orient = opnd;
        OpPremul: begin
          hamilton(opnd, orient, prod, sat);
          orient = prod;
        end
        OpPostmul: begin
          hamilton(orient, opnd, prod, sat);
          orient = prod;
        end
        default: ;
      endcase
      for (int i = 0; i < NumComp; i++) e.quat[i] = comp_t'(orient[i]);
      e.sat = sat;
      expected_q.push_back(e);
      n_ops[op]++;
      if (sat) n_sat++;
    endfunction

    function void check_result(logic [TdataW-1:0] data, logic sat);
      payload_t got;
      payload_t e;
      bit       bad;
      got.quat = data[QuatW-1:0];
      got.sat = sat;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("%0t: result with none expected: x=%0d y=%0d z=%0d w=%0d sat=%0b",
                   $time, $signed(got.quat[IdxX]), $signed(got.quat[IdxY]),
                   $signed(got.quat[IdxZ]), $signed(got.quat[IdxW]), got.sat);
        return;
      end
      e = expected_q.pop_front();
      bad = 1'b0;
      for (int i = 0; i < NumComp; i++)
        if (got.quat[i] !== e.quat[i]) bad = 1'b1;
      if (got.sat !== e.sat) bad = 1'b1;
      if (bad) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("%0t: exp x=%0d y=%0d z=%0d w=%0d sat=%0b, got x=%0d y=%0d z=%0d w=%0d sat=%0b",
                   $time, $signed(e.quat[IdxX]), $signed(e.quat[IdxY]),
                   $signed(e.quat[IdxZ]), $signed(e.quat[IdxW]), e.sat,
                   $signed(got.quat[IdxX]), $signed(got.quat[IdxY]),
                   $signed(got.quat[IdxZ]), $signed(got.quat[IdxW]), got.sat);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [TdataW-1:0] s_axis_tdata = '0;
  logic [OpW-1:0]    s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [TdataW-1:0] m_axis_tdata;
  logic              m_axis_tuser;

  orientation_scoreboard sb = new();

  bit  tx_bursty = 1'b0;
  int  rx_mode = 0;
  bit  hold_req = 1'b0;
  int  hold_left = 0;
  int  rx_cyc = 0;
  int  burst_left = 0;
  int  idle_cycles = 0;

  quaternion_product_accumulator_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // receiver stall patterns, long hold-off counted here
  always @(negedge clk_i) begin
    rx_cyc++;
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 9) < 7);
        2: m_axis_tready <= ((rx_cyc % 8) < 5);
        default: m_axis_tready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // transaction monitor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready)
        sb.note_item(opcode_e'(s_axis_tuser), s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Timeout after %0d cycles without a transaction", idle_cycles);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic [TdataW-1:0] pack(comp_t x, comp_t y, comp_t z, comp_t w);
    return {w, z, y, x};
  endfunction

  function automatic comp_t rand_comp(int kind);
    int unsigned sel;
    case (kind)
      0: return comp_t'($urandom_range(0, 65535));
      1: return comp_t'(int'($urandom_range(0, 16384)) - 8192);
      default: begin
        sel = $urandom_range(0, 6);
        case (sel)
          0: return 16'h7FFF;
          1: return 16'h8000;
          2: return 16'h0000;
          3: return 16'h0001;
          4: return 16'hFFFF;
          5: return 16'h4000;
          default: return 16'hC000;
        endcase
      end
    endcase
  endfunction

  function automatic logic [TdataW-1:0] rand_quat();
    int unsigned k;
    int kind;
    k = $urandom_range(0, 9);
    kind = (k < 3) ? 0 : (k < 8) ? 1 : 2;
    return pack(rand_comp(kind), rand_comp(kind), rand_comp(kind), rand_comp(kind));
  endfunction

  function automatic opcode_e rand_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 15) return OpLoad;
    if (r < 45) return OpPremul;
    if (r < 75) return OpPostmul;
    return OpRead;
  endfunction

  task automatic idle_tx(int n);
    repeat (n) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata <= {$urandom, $urandom};
    end
  endtask

  task automatic send_item(opcode_e op, logic [TdataW-1:0] data);
    if (tx_bursty && burst_left == 0) begin
      idle_tx($urandom_range(1, 8));
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= data;
    s_axis_tuser <= op;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  task automatic wait_drained();
    idle_tx(1);
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed
    send_item(OpRead, pack(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF));
    send_item(OpLoad, pack(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_item(OpRead, pack(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(OpPostmul, pack(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
    send_item(OpLoad, pack(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_item(OpPremul, pack(16'h8000, 16'h8000, 16'h8000, 16'h8000));
    send_item(OpPostmul, pack(16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_item(OpLoad, pack(16'h0000, 16'h0000, 16'h0000, 16'h0001));
    send_item(OpPostmul, pack(16'h0000, 16'h0000, 16'h0000, 16'h2000));
    send_item(OpPostmul, pack(16'h0000, 16'h0000, 16'h0000, 16'hE000));
    send_item(OpLoad, pack(16'h0000, 16'h0000, 16'h0000, 16'h4000));
    send_item(OpPremul, pack(16'h4000, 16'h0000, 16'h0000, 16'h0000));
    send_item(OpPostmul, pack(16'h0000, 16'h4000, 16'h0000, 16'h0000));
    send_item(OpPremul, pack(16'h0000, 16'h0000, 16'hC000, 16'h0000));
    send_item(OpRead, pack(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
    send_item(OpLoad, pack(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF));
    send_item(OpPostmul, pack(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
    send_item(OpLoad, pack(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA));
    send_item(OpPremul, pack(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555));
    send_item(OpLoad, pack(16'h0001, 16'hFFFF, 16'h0001, 16'hFFFF));
    send_item(OpPostmul, pack(16'hFFFF, 16'h0001, 16'hFFFF, 16'h0001));
    send_item(OpPremul, pack(16'h2D41, 16'h0000, 16'h0000, 16'h2D41));

    // random phases with different idle patterns
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin tx_bursty = 1'b0; rx_mode = 0; end
        1: begin tx_bursty = 1'b1; rx_mode = 1; end
        2: begin tx_bursty = 1'b1; rx_mode = 2; end
        3: begin tx_bursty = 1'b0; rx_mode = 3; end
        default: begin tx_bursty = 1'b1; rx_mode = 1; end
      endcase
      burst_left = 0;
      for (int i = 0; i < RandItems / 5; i++) begin
        if (ph == 2 && i == 20) hold_req = 1'b1;
        if (ph == 3 && i % 40 == 0) wait_drained();
        send_item(rand_op(), rand_quat());
      end
    end

    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("Checked %0d loads, %0d premultiplies, %0d postmultiplies, %0d reads",
             sb.n_ops[OpLoad], sb.n_ops[OpPremul], sb.n_ops[OpPostmul], sb.n_ops[OpRead]);
    $display("%0d results saturated, %0d mismatches", sb.n_sat, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
